FILE: sv/car_pkg.sv
package car_pkg;

   localparam int COUNT_BITS  = 20;
   localparam int FRAC_BITS   = 16;
   localparam int PHASE_BITS  = COUNT_BITS + FRAC_BITS;
   localparam int STEP_BITS   = 24;
   localparam int SAMPLE_BITS = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int MAX_RESULTS = 48;
   localparam int RUN_BITS    = 6;
   localparam int COEF_BITS   = 24;
   localparam int PROD_BITS   = COEF_BITS + FRAC_BITS + 1;
   localparam int DIFF_BITS   = COUNT_BITS + 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_RATIO   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUTPUT_COUNT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IN_WIDTH     = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_WIDTH    = 2'd3;

   typedef struct packed {
      logic accept;
      logic setup;
      logic mul_a;
      logic mul_t;
      logic add_b;
      logic add_c;
      logic finish;
      logic emit;
      logic end_call;
   } car_cmd_type;

   typedef struct packed {
      logic more;
      logic up;
      logic rsp_free;
   } car_status_type;

   function automatic logic [1:0] clamp_index(input logic signed [DIFF_BITS-1:0] rel);
      logic [1:0] r;
      if (rel < 0) r = 2'd0;
      else if (rel > 3) r = 2'd3;
      else r = rel[1:0];
      return r;
   endfunction

endpackage

FILE: sv/car_ctrl.sv
module car_ctrl
   import car_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  car_status_type status,
   output car_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_M1    = 4'd2;
   localparam logic [3:0] ST_A1    = 4'd3;
   localparam logic [3:0] ST_M2    = 4'd4;
   localparam logic [3:0] ST_A2    = 4'd5;
   localparam logic [3:0] ST_M3    = 4'd6;
   localparam logic [3:0] ST_A3    = 4'd7;
   localparam logic [3:0] ST_EVAL  = 4'd8;
   localparam logic [3:0] ST_END   = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.more) begin
               cmd.setup = 1'b1;
               state_in = status.up ? ST_M1 : ST_A3;
            end else begin
               state_in = ST_END;
            end
         end
         ST_M1: begin
            cmd.mul_a = 1'b1;
            state_in = ST_A1;
         end
         ST_A1: begin
            cmd.add_b = 1'b1;
            state_in = ST_M2;
         end
         ST_M2: begin
            cmd.mul_t = 1'b1;
            state_in = ST_A2;
         end
         ST_A2: begin
            cmd.add_c = 1'b1;
            state_in = ST_M3;
         end
         ST_M3: begin
            cmd.mul_t = 1'b1;
            state_in = ST_A3;
         end
         ST_A3: begin
            cmd.finish = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_END: begin
            cmd.end_call = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

FILE: sv/car_datapath.sv
module car_datapath
   import car_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [STEP_BITS-1:0]          csr_write_data,
   input  logic [SAMPLE_BITS-1:0]        req_sample_in,
   input  logic                          req_last_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_last_of_run,
   output logic                          rsp_last_of_stream,
   input  car_cmd_type                   cmd,
   output car_status_type                status
);

   logic [STEP_BITS-1:0]  step_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  in_sel_ff, out_sel_ff;

   logic signed [SAMPLE_BITS-1:0] win_ff [4];
   logic [PHASE_BITS-1:0] phase_ff;
   logic [COUNT_BITS-1:0] emitted_ff, taken_ff;
   logic [RUN_BITS-1:0]   run_ff;
   logic                  last_ff;

   logic signed [COEF_BITS-1:0]   a_ff, b_ff, c_ff, t_ff;
   logic signed [SAMPLE_BITS-1:0] x0_ff, pick_ff, y_ff;
   logic signed [FRAC_BITS:0]     f_ff;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic                          rsp_valid_ff, run_last_ff, stream_last_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;

   logic signed [SAMPLE_BITS-1:0] dec_in;
   logic [COUNT_BITS-1:0]         ip;
   logic signed [DIFF_BITS-1:0]   d;
   logic                          up, beyond;
   logic signed [SAMPLE_BITS-1:0] xm1, x0, x1, x2, pk;
   logic signed [COEF_BITS-1:0]   sa, sb, sc, va, vb5, vc;
   logic signed [PROD_BITS-1:0]   prod_in, prod_rnd;
   logic signed [PROD_BITS-FRAC_BITS-1:0] tr;
   logic signed [COEF_BITS+1:0]   ysum;
   logic signed [SAMPLE_BITS-1:0] y_clip, y_enc;

   assign up = step_ff < STEP_BITS'(1 << FRAC_BITS);
   assign ip = phase_ff[PHASE_BITS-1:FRAC_BITS];
   assign d  = $signed({2'b00, ip}) - $signed({2'b00, taken_ff});
   assign beyond = up ? ({1'b0, ip} + (COUNT_BITS+1)'(2) > {1'b0, taken_ff})
                      : (ip > taken_ff);

   assign status.more = (run_ff < RUN_BITS'(MAX_RESULTS)) && (emitted_ff < count_ff)
                        && (last_ff || !beyond);
   assign status.up = up;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign dec_in = in_sel_ff ? $signed(req_sample_in)
                             : $signed({req_sample_in[7] ^ 1'b1, req_sample_in[6:0], 8'h00});

   assign xm1 = win_ff[clamp_index(d + DIFF_BITS'(2))];
   assign x0  = win_ff[clamp_index(d + DIFF_BITS'(3))];
   assign x1  = win_ff[clamp_index(d + DIFF_BITS'(4))];
   assign x2  = win_ff[clamp_index(d + DIFF_BITS'(5))];
   assign pk  = x0;

   assign va  = COEF_BITS'(3) * (COEF_BITS'(x0) - COEF_BITS'(x1)) - COEF_BITS'(xm1)
                + COEF_BITS'(x2);
   assign sa  = (va + ((va < 0) ? COEF_BITS'(1) : COEF_BITS'(0))) >>> 1;
   assign vb5 = COEF_BITS'(5) * COEF_BITS'(x0) + COEF_BITS'(x2);
   assign sb  = COEF_BITS'(2) * COEF_BITS'(x1) + COEF_BITS'(xm1)
                - ((vb5 + ((vb5 < 0) ? COEF_BITS'(1) : COEF_BITS'(0))) >>> 1);
   assign vc  = COEF_BITS'(x1) - COEF_BITS'(xm1);
   assign sc  = (vc + ((vc < 0) ? COEF_BITS'(1) : COEF_BITS'(0))) >>> 1;

   assign prod_in = (cmd.mul_a ? a_ff : t_ff) * f_ff;
   assign prod_rnd = prod_ff + (prod_ff[PROD_BITS-1] ? PROD_BITS'((1 << FRAC_BITS) - 1)
                                                     : PROD_BITS'(0));
   assign tr = prod_rnd[PROD_BITS-1:FRAC_BITS];
   assign ysum = (COEF_BITS+2)'(tr) + (COEF_BITS+2)'(x0_ff);
   assign y_clip = (ysum > 32767) ? 16'sh7fff : (ysum < -32768) ? 16'sh8000
                                              : ysum[SAMPLE_BITS-1:0];
   assign y_enc = out_sel_ff ? y_ff : (y_ff >>> 8);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_BITS'(1 << FRAC_BITS);
         count_ff   <= '0;
         in_sel_ff  <= 1'b1;
         out_sel_ff <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_STEP_RATIO:   step_ff    <= csr_write_data;
            CSR_OUTPUT_COUNT: count_ff   <= csr_write_data[COUNT_BITS-1:0];
            CSR_IN_WIDTH:     in_sel_ff  <= csr_write_data[0];
            CSR_OUT_WIDTH:    out_sel_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) win_ff[i] <= '0;
         phase_ff   <= '0;
         emitted_ff <= '0;
         taken_ff   <= '0;
         run_ff     <= '0;
         last_ff    <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (taken_ff == '0) begin
               for (int i = 0; i < 4; i++) win_ff[i] <= dec_in;
            end else begin
               win_ff[0] <= win_ff[1];
               win_ff[1] <= win_ff[2];
               win_ff[2] <= win_ff[3];
               win_ff[3] <= dec_in;
            end
            run_ff  <= '0;
            last_ff <= req_last_in;
         end
         if (cmd.finish) begin
            phase_ff   <= phase_ff + PHASE_BITS'(step_ff);
            emitted_ff <= emitted_ff + 1'b1;
            run_ff     <= run_ff + 1'b1;
         end
         if (cmd.end_call) begin
            if (last_ff) begin
               for (int i = 0; i < 4; i++) win_ff[i] <= '0;
               phase_ff   <= '0;
               emitted_ff <= '0;
               taken_ff   <= '0;
            end else begin
               taken_ff <= taken_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         a_ff    <= sa;
         b_ff    <= sb;
         c_ff    <= sc;
         x0_ff   <= x0;
         pick_ff <= pk;
         f_ff    <= $signed({1'b0, phase_ff[FRAC_BITS-1:0]});
      end
      if (cmd.mul_a || cmd.mul_t) prod_ff <= prod_in;
      if (cmd.add_b) t_ff <= COEF_BITS'(tr) + b_ff;
      if (cmd.add_c) t_ff <= COEF_BITS'(tr) + c_ff;
      if (cmd.finish) y_ff <= up ? y_clip : pick_ff;
      if (cmd.emit) begin
         rsp_sample_ff  <= y_enc;
         run_last_ff    <= !status.more;
         stream_last_ff <= (emitted_ff == count_ff) || (!status.more && last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_last_of_run    = run_last_ff;
   assign rsp_last_of_stream = stream_last_ff;

endmodule

FILE: sv/cubic_audio_resampler_core.sv
// Mono cubic resampler. Each request carries one sample; it produces zero to 48
// results. After a request is accepted, each result goes through, when upsampling,
// a run check, three multiplies by the phase fraction through one shared multiplier,
// each followed by a truncate-and-add, and the emit; when picking, through a run
// check, a select and the emit. The emit waits while the result register still
// holds a result stalled by rsp_stall. A final run check and a closing step come
// before the next request is taken. No new request is taken while the previous run is in progress.
module cubic_audio_resampler_core
   import car_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [STEP_BITS-1:0]          csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [SAMPLE_BITS-1:0]        req_sample_in,
   input  logic                          req_last_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_last_of_run,
   output logic                          rsp_last_of_stream
);

   car_cmd_type    cmd;
   car_status_type status;

   car_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   car_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_sample_in      (req_sample_in),
      .req_last_in        (req_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_last_of_stream (rsp_last_of_stream),
      .cmd                (cmd),
      .status             (status)
   );

endmodule
